### sv/sst_pkg.sv
package sst_pkg;

   localparam int KEY_W   = 64;
   localparam int SCORE_W = 31;
   localparam int FIELD_W = 7;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_DUMP   = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [KEY_W-1:0]   player_key;
      logic [SCORE_W-1:0] new_score;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]   entry_key;
      logic [SCORE_W-1:0] entry_score;
      logic [FIELD_W-1:0] position;
      logic [FIELD_W-1:0] entry_count;
      logic               removed_old;
      logic               dropped;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_REMOVE,
      CELL_INSERT,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [SCORE_W-1:0] score;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_DUMP
   } state_type;

endpackage

### sv/sorted_score_table_core.sv
// Ranked table of up to DEPTH (key, score) entries in descending score order, held in a
// row of cells. The cycle an update beat is accepted removes the first entry with the
// same key; the insert state then shifts the new entry into place and loads the result
// register, waiting while that register holds an untaken result, and the input stalls
// until the insert is done. A dump beat streams one entry per cycle, while the result
// register is free, by rotating the used cells towards the head; an empty table gives
// a single beat marked last. Only the low KEY_BITS bits of a key are stored and compared.
module sorted_score_table_core #(
   parameter int DEPTH    = 32,
   parameter int KEY_BITS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sst_pkg::rsp_type rsp_data
);

   localparam int CntW   = $clog2(DEPTH + 1);
   localparam int KeyW   = sst_pkg::KEY_W;
   localparam int FieldW = sst_pkg::FIELD_W;

   sst_pkg::state_type          state_ff, state_in;
   logic [CntW-1:0]             count_ff, count_in;
   logic [CntW-1:0]             idx_ff, idx_in;
   logic                        removed_ff, removed_in;
   logic [KEY_BITS-1:0]         key_ff, key_in;
   logic [sst_pkg::SCORE_W-1:0] score_ff, score_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   sst_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   sst_pkg::cell_ctrl_type      ctrl;
   logic                        rsp_load;
   logic                        accept;
   logic                        out_free;
   logic                        any_match;
   logic                        full;
   logic                        dump_last;
   logic [KEY_BITS-1:0]         cmp_key;
   logic [CntW-1:0]             pos;

   logic [DEPTH-1:0]            valid_vec;
   logic [DEPTH-1:0]            match_vec;
   logic [DEPTH-1:0]            ge_vec;
   logic [DEPTH-1:0]            above_vec;
   logic [DEPTH-1:0]            edge_vec;
   logic [KEY_BITS-1:0]         key_arr [DEPTH];
   logic [sst_pkg::SCORE_W-1:0] score_arr [DEPTH];

   assign req_stall = (state_ff != sst_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign any_match = |match_vec;
   assign full      = (count_ff == CntW'(DEPTH));
   assign dump_last = (idx_ff == (count_ff - CntW'(1)));
   assign cmp_key   = (state_ff == sst_pkg::ST_IDLE) ? req_data.player_key[KEY_BITS-1:0]
                                                     : key_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                        prv_valid, prv_ge, nxt_valid;
      logic [KEY_BITS-1:0]         prv_key, nxt_key;
      logic [sst_pkg::SCORE_W-1:0] prv_score, nxt_score;

      if (i == 0) begin : g_head
         assign prv_valid    = 1'b1;
         assign prv_ge       = 1'b1;
         assign prv_key      = '0;
         assign prv_score    = '0;
         assign above_vec[i] = 1'b0;
         assign edge_vec[i]  = !ge_vec[i];
      end else begin : g_body
         assign prv_valid    = valid_vec[i-1];
         assign prv_ge       = ge_vec[i-1];
         assign prv_key      = key_arr[i-1];
         assign prv_score    = score_arr[i-1];
         assign above_vec[i] = |match_vec[i-1:0];
         assign edge_vec[i]  = !ge_vec[i] && ge_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign nxt_valid = 1'b0;
         assign nxt_key   = '0;
         assign nxt_score = '0;
      end else begin : g_link
         assign nxt_valid = valid_vec[i+1];
         assign nxt_key   = key_arr[i+1];
         assign nxt_score = score_arr[i+1];
      end

      sst_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_key     (cmp_key),
         .prv_valid   (prv_valid),
         .prv_ge      (prv_ge),
         .prv_key     (prv_key),
         .prv_score   (prv_score),
         .nxt_valid   (nxt_valid),
         .nxt_key     (nxt_key),
         .nxt_score   (nxt_score),
         .head_key    (key_arr[0]),
         .head_score  (score_arr[0]),
         .match_above (above_vec[i]),
         .valid       (valid_vec[i]),
         .key         (key_arr[i]),
         .score       (score_arr[i]),
         .match       (match_vec[i]),
         .ge          (ge_vec[i])
      );
   end

   // insert position: first cell that is empty or whose score is below the new one, DEPTH if none
   always_comb begin
      pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pos = pos | (edge_vec[i] ? CntW'(i) : '0);
      end
      if (edge_vec == '0) begin
         pos = CntW'(DEPTH);
      end
   end

   // drive the cells: remove on an update beat, then insert, or rotate one dump entry
   always_comb begin
      ctrl.score = score_ff;
      ctrl.op    = sst_pkg::CELL_HOLD;
      case (state_ff)
         sst_pkg::ST_IDLE: begin
            if (accept && (req_data.cmd == sst_pkg::CMD_UPDATE)) begin
               ctrl.op = sst_pkg::CELL_REMOVE;
            end
         end
         sst_pkg::ST_INSERT: begin
            if (out_free) begin
               ctrl.op = sst_pkg::CELL_INSERT;
            end
         end
         sst_pkg::ST_DUMP: begin
            if (out_free && (count_ff != '0)) begin
               ctrl.op = sst_pkg::CELL_ROTATE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sst_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.cmd == sst_pkg::CMD_DUMP) ? sst_pkg::ST_DUMP
                                                               : sst_pkg::ST_INSERT;
            end
         end
         sst_pkg::ST_INSERT: begin
            if (out_free) begin
               state_in = sst_pkg::ST_IDLE;
            end
         end
         sst_pkg::ST_DUMP: begin
            if (out_free && ((count_ff == '0) || dump_last)) begin
               state_in = sst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_load    = 1'b0;
      rsp_data_in = '0;
      count_in    = count_ff;
      idx_in      = idx_ff;
      removed_in  = removed_ff;
      key_in      = key_ff;
      score_in    = score_ff;
      case (state_ff)
         sst_pkg::ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               key_in   = req_data.player_key[KEY_BITS-1:0];
               score_in = req_data.new_score;
               if (req_data.cmd == sst_pkg::CMD_UPDATE) begin
                  removed_in = any_match;
                  count_in   = count_ff - CntW'(any_match);
               end
            end
         end
         sst_pkg::ST_INSERT: begin
            if (out_free) begin
               rsp_load                = 1'b1;
               count_in                = full ? count_ff : (count_ff + CntW'(1));
               rsp_data_in.position    = FieldW'(pos);
               rsp_data_in.entry_count = FieldW'(count_in);
               rsp_data_in.removed_old = removed_ff;
               rsp_data_in.dropped     = full;
               rsp_data_in.last        = 1'b1;
            end
         end
         sst_pkg::ST_DUMP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (count_ff == '0) begin
                  rsp_data_in.last = 1'b1;
               end else begin
                  rsp_data_in.entry_key   = KeyW'(key_arr[0]);
                  rsp_data_in.entry_score = score_arr[0];
                  rsp_data_in.position    = FieldW'(idx_ff);
                  rsp_data_in.entry_count = FieldW'(count_ff);
                  rsp_data_in.last        = dump_last;
                  idx_in                  = idx_ff + CntW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // hold the result beat while stalled, drop it once taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         removed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff   <= key_in;
      score_ff <= score_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/sst_cell.sv
module sst_cell #(
   parameter int KEY_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sst_pkg::cell_ctrl_type        ctrl,
   input  logic [KEY_BITS-1:0]           new_key,
   input  logic                          prv_valid,
   input  logic                          prv_ge,
   input  logic [KEY_BITS-1:0]           prv_key,
   input  logic [sst_pkg::SCORE_W-1:0]   prv_score,
   input  logic                          nxt_valid,
   input  logic [KEY_BITS-1:0]           nxt_key,
   input  logic [sst_pkg::SCORE_W-1:0]   nxt_score,
   input  logic [KEY_BITS-1:0]           head_key,
   input  logic [sst_pkg::SCORE_W-1:0]   head_score,
   input  logic                          match_above,
   output logic                          valid,
   output logic [KEY_BITS-1:0]           key,
   output logic [sst_pkg::SCORE_W-1:0]   score,
   output logic                          match,
   output logic                          ge
);

   logic                        valid_ff, valid_in;
   logic [KEY_BITS-1:0]         key_ff, key_in;
   logic [sst_pkg::SCORE_W-1:0] score_ff, score_in;

   assign match = valid_ff && (key_ff == new_key);
   assign ge    = valid_ff && (score_ff >= ctrl.score);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      score_in = score_ff;
      case (ctrl.op)
         sst_pkg::CELL_REMOVE: begin
            // close the gap left by the first matching entry
            if (match_above || match) begin
               valid_in = nxt_valid;
               key_in   = nxt_key;
               score_in = nxt_score;
            end
         end
         sst_pkg::CELL_INSERT: begin
            if (!ge) begin
               if (prv_ge) begin
                  valid_in = 1'b1;
                  key_in   = new_key;
                  score_in = ctrl.score;
               end else begin
                  valid_in = prv_valid;
                  key_in   = prv_key;
                  score_in = prv_score;
               end
            end
         end
         sst_pkg::CELL_ROTATE: begin
            // advance towards the head; the last used cell takes the head
            if (nxt_valid) begin
               key_in   = nxt_key;
               score_in = nxt_score;
            end else if (valid_ff) begin
               key_in   = head_key;
               score_in = head_score;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      score_ff <= score_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign score = score_ff;

endmodule

### tb/score_rank_checker.sv
`timescale 1ns / 1ps

module score_rank_checker #(
   parameter int DEPTH    = 32,
   parameter int KEY_BITS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  sst_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  sst_pkg::rsp_type rsp_data,
   output int unsigned      mismatch_count,
   output int unsigned      pending
);

   localparam int KEY_W   = sst_pkg::KEY_W;
   localparam int SCORE_W = sst_pkg::SCORE_W;
   localparam int FIELD_W = sst_pkg::FIELD_W;

   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

   logic [KEY_W-1:0]   rank_key   [DEPTH];
   logic [SCORE_W-1:0] rank_score [DEPTH];
   int unsigned        rank_count;
   sst_pkg::rsp_type   expected_rows [$];

   task automatic check_field(input string label, input logic [KEY_W-1:0] want,
                              input logic [KEY_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", label, want, got);
         mismatch_count++;
      end
   endtask

   // Work out the result beats of one accepted request and update the ranking.
   task automatic predict_rank_results(input sst_pkg::req_type item);
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
      int                 i;
      int                 j;
      int                 slot;
      logic               removed;
      logic               fell_off;
      sst_pkg::rsp_type   row;
      key      = item.player_key & KEY_MASK;
      score    = item.new_score;
      removed  = 1'b0;
      fell_off = 1'b0;
      if (item.cmd == sst_pkg::CMD_DUMP) begin
         if (rank_count == 0) begin
            row      = '0;
            row.last = 1'b1;
            expected_rows.push_back(row);
         end else begin
            for (i = 0; i < rank_count; i++) begin
               row             = '0;
               row.entry_key   = rank_key[i];
               row.entry_score = rank_score[i];
               row.position    = FIELD_W'(i);
               row.entry_count = FIELD_W'(rank_count);
               row.last        = (i + 1 == rank_count);
               expected_rows.push_back(row);
            end
         end
         return;
      end
      // drop the first entry holding this key, closing the gap
      for (i = 0; i < rank_count; i++) begin
         if (rank_key[i] == key) begin
            for (j = i; j + 1 < rank_count; j++) begin
               rank_key[j]   = rank_key[j + 1];
               rank_score[j] = rank_score[j + 1];
            end
            rank_count--;
            removed = 1'b1;
            break;
         end
      end
      // equal scores keep arrival order, so go past them
      slot = 0;
      while (slot < rank_count && rank_score[slot] >= score)
         slot++;
      if (rank_count >= DEPTH) begin
         fell_off = 1'b1;
         if (slot < DEPTH) begin
            for (i = DEPTH - 1; i > slot; i--) begin
               rank_key[i]   = rank_key[i - 1];
               rank_score[i] = rank_score[i - 1];
            end
            rank_key[slot]   = key;
            rank_score[slot] = score;
         end else begin
            slot = DEPTH;
         end
         rank_count = DEPTH;
      end else begin
         for (i = rank_count; i > slot; i--) begin
            rank_key[i]   = rank_key[i - 1];
            rank_score[i] = rank_score[i - 1];
         end
         rank_key[slot]   = key;
         rank_score[slot] = score;
         rank_count++;
      end
      row             = '0;
      row.position    = FIELD_W'(slot);
      row.entry_count = FIELD_W'(rank_count);
      row.removed_old = removed;
      row.dropped     = fell_off;
      row.last        = 1'b1;
      expected_rows.push_back(row);
   endtask

   always @(posedge clock) begin
      sst_pkg::rsp_type want;
      if (reset) begin
         rank_count = 0;
         expected_rows.delete();
      end else begin
         // results are registered, so a beat out never belongs to the beat in at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               $error("result beat with nothing expected: %h", rsp_data);
               mismatch_count++;
            end else begin
               want = expected_rows.pop_front();
               check_field("entry_key", want.entry_key, rsp_data.entry_key);
               check_field("entry_score", KEY_W'(want.entry_score),
                           KEY_W'(rsp_data.entry_score));
               check_field("position", KEY_W'(want.position), KEY_W'(rsp_data.position));
               check_field("entry_count", KEY_W'(want.entry_count),
                           KEY_W'(rsp_data.entry_count));
               check_field("removed_old", KEY_W'(want.removed_old),
                           KEY_W'(rsp_data.removed_old));
               check_field("dropped", KEY_W'(want.dropped), KEY_W'(rsp_data.dropped));
               check_field("last", KEY_W'(want.last), KEY_W'(rsp_data.last));
            end
         end
         if (req_valid && !req_stall)
            predict_rank_results(req_data);
      end
      pending = expected_rows.size();
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int KEY_W          = sst_pkg::KEY_W;
   localparam int SCORE_W        = sst_pkg::SCORE_W;
   localparam int DEPTH          = 32;
   localparam int KEY_BITS       = 64;
   localparam int KEY_POOL       = 48;
   localparam int PHASE_ITEMS    = 128;
   localparam int LONG_HOLD      = 240;
   localparam int WATCHDOG_LIMIT = 2000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sst_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   sst_pkg::rsp_type rsp_data;

   int unsigned mismatch_count;
   int unsigned pending;

   int unsigned      send_idle_pct = 0;
   int unsigned      rsp_stall_pct = 0;
   logic             long_hold_due = 1'b0;
   logic             hold_begun    = 1'b0;
   int               hold_left     = 0;
   int               quiet_cycles  = 0;
   logic [KEY_W-1:0] key_pool [KEY_POOL];

   always #6 clock = ~clock;

   sorted_score_table_core #(
      .DEPTH   (DEPTH),
      .KEY_BITS(KEY_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   score_rank_checker #(
      .DEPTH   (DEPTH),
      .KEY_BITS(KEY_BITS)
   ) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .pending       (pending)
   );

   // Receiver: one long hold when asked, random stalls otherwise.
   always @(posedge clock) begin
      if (long_hold_due && !hold_begun) begin
         hold_begun = 1'b1;
         hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** sorted_score_table_core: FAILED **");
         $finish;
      end
   end

   task automatic send_beat(input logic cmd, input logic [KEY_W-1:0] key,
                            input logic [SCORE_W-1:0] score);
      sst_pkg::req_type item;
      item.cmd        = cmd;
      item.player_key = key;
      item.new_score  = score;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random_beat();
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
      int unsigned        pick;
      key   = {$urandom(), $urandom()};
      score = SCORE_W'($urandom());
      pick  = $urandom_range(99);
      if (pick < 8) begin
         // key and score are noise on a dump
         send_beat(sst_pkg::CMD_DUMP, key, score);
      end else begin
         if ($urandom_range(99) < 85)
            key = key_pool[$urandom_range(KEY_POOL - 1)];
         pick = $urandom_range(99);
         if (pick < 40)
            score = SCORE_W'($urandom_range(15));
         else if (pick < 50)
            score = $urandom_range(1) ? {SCORE_W{1'b1}} : '0;
         send_beat(sst_pkg::CMD_UPDATE, key, score);
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < KEY_POOL; i++)
         key_pool[i] = {$urandom(), $urandom()};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 18;
      rsp_stall_pct = 77;

      // empty dump first, then extremes, ties and re-scoring of known keys
      send_beat(sst_pkg::CMD_DUMP, {KEY_W{1'b1}}, {SCORE_W{1'b1}});
      send_beat(sst_pkg::CMD_UPDATE, {KEY_W{1'b1}}, {SCORE_W{1'b1}});
      send_beat(sst_pkg::CMD_UPDATE, '0, '0);
      send_beat(sst_pkg::CMD_UPDATE, 64'h0123_4567_89ab_cdef, 31'h4000_0000);
      send_beat(sst_pkg::CMD_UPDATE, '0, {SCORE_W{1'b1}});
      send_beat(sst_pkg::CMD_UPDATE, {KEY_W{1'b1}}, '0);
      send_beat(sst_pkg::CMD_DUMP, '0, '0);
      send_beat(sst_pkg::CMD_UPDATE, 64'haaaa_aaaa_aaaa_aaaa, 31'h2aaa_aaaa);
      send_beat(sst_pkg::CMD_UPDATE, 64'h5555_5555_5555_5555, 31'h5555_5555);
      send_beat(sst_pkg::CMD_UPDATE, 64'd1, 31'd5);
      send_beat(sst_pkg::CMD_UPDATE, 64'd2, 31'd5);
      send_beat(sst_pkg::CMD_UPDATE, 64'd3, 31'd5);
      send_beat(sst_pkg::CMD_UPDATE, 64'd1, 31'd5);
      send_beat(sst_pkg::CMD_UPDATE, 64'h0123_4567_89ab_cdef, 31'd5);
      send_beat(sst_pkg::CMD_DUMP, '0, '0);

      for (i = 0; i < PHASE_ITEMS; i++)
         send_random_beat();

      send_idle_pct = 77;
      rsp_stall_pct = 18;
      for (i = 0; i < PHASE_ITEMS; i++)
         send_random_beat();

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // hold the result side while beats keep coming, so the input backs up
      long_hold_due <= 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++)
         send_random_beat();

      req_valid <= 1'b0;
      // let the checker count the last beat before waiting on it
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && pending == 0)
         $display("** sorted_score_table_core: PASSED **");
      else
         $display("** sorted_score_table_core: FAILED **");
      $finish;
   end

endmodule
